@@ rtl/core/fms_pkg.sv @@
// ----------------------------------------------------------------------------
// Flight mode supervisor package
// Mode and function codes, field widths and the word structs shared by the
// supervisor top level and its decision core.
// ----------------------------------------------------------------------------
`default_nettype none

package fms_pkg;

  // Flight modes, in the encoding the rest of the system assumes
  typedef enum logic [2:0] {
    MODE_SAFE   = 3'd0,
    MODE_PANIC  = 3'd1,
    MODE_MANUAL = 3'd2,
    MODE_CALIB  = 3'd3,
    MODE_YAW    = 3'd4,
    MODE_FULL   = 3'd5
  } mode_t;

  // Kind of input word, carried on tuser
  typedef enum logic [1:0] {
    FN_MODE_MSG    = 2'd0,
    FN_PANIC_CHECK = 2'd1,
    FN_FAULT       = 2'd2,
    FN_CALIB_DONE  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic CFG_PANIC_HOLD = 1'b0;
  localparam logic CFG_CONFIRM    = 1'b1;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned CONFIRM_W   = 3;
  localparam int unsigned IN_DATA_W   = 80;  // 73 field bits padded to bytes
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 8;   // 7 field bits padded to a byte

  localparam logic [CFG_DATA_W-1:0] PANIC_HOLD_RST = 32'd2000000;
  localparam logic [CONFIRM_W-1:0]  CONFIRM_RST    = 3'd3;

  // One input word as the core sees it
  typedef struct packed {
    func_t            func;
    logic [2:0]       req;
    logic [NOW_W-1:0] now;
    logic             neutral;
  } item_t;

  // One result word
  typedef struct packed {
    mode_t      mode;
    logic       calib;
    logic [2:0] led;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/flight_mode_supervisor.sv @@
// An accepted input word waits in the input register, passes the decision core and is
// registered in the result register, which presents it with m_axis_tvalid.
// Throughput: one word per cycle while the output is not stalled; input register, decision core, result register.
// The input register can refill while a result waits; the input side stalls once that
// register holds a word that cannot move on to the stalled result register.
// Reset (rst, synchronous): mode SAFE, calibration cleared, no panic stamp,
// panic_hold_us = 2000000, confirm_count = 3, both stages empty.
// ----------------------------------------------------------------------------
// Flight mode supervisor
// Streaming wrapper around the decision core with configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module flight_mode_supervisor #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  // Configuration write port
  input  wire                              cfg_we,
  input  wire                              cfg_index,
  input  wire [fms_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: requested_mode[2:0], now_us[34:3], stick_lift[44:35],
  //        stick_roll[53:45], stick_pitch[62:54], stick_yaw[72:63], zero pad
  input  wire [fms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: func[1:0]
  input  wire [fms_pkg::IN_USER_W-1:0]     s_axis_tuser,
  // Output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tdata: current_mode[2:0], is_calibrated[3], led_code[6:4], zero pad
  output logic [fms_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import fms_pkg::*;

  logic [CFG_DATA_W-1:0] panic_hold_us;
  logic [CONFIRM_W-1:0]  confirm_count;

  logic                  in_valid;
  logic [IN_DATA_W-1:0]  in_data;
  logic [IN_USER_W-1:0]  in_user;
  logic                  advance;
  item_t                 item;
  result_t               result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      panic_hold_us <= PANIC_HOLD_RST;
      confirm_count <= CONFIRM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANIC_HOLD: panic_hold_us <= cfg_data;
        CFG_CONFIRM:    confirm_count <= cfg_data[CONFIRM_W-1:0];
        default:        panic_hold_us <= panic_hold_us;
      endcase
    end
  end

  // Handshake: move a word forward when the result register is free
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
      in_user <= s_axis_tuser;
    end
  end

  // Unpack the held word; sticks are neutral only when all are zero
  assign item.func    = func_t'(in_user);
  assign item.req     = in_data[2:0];
  assign item.now     = in_data[34:3];
  assign item.neutral = (in_data[72:35] == '0);

  fms_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (item),
    .panic_hold_us (panic_hold_us),
    .confirm_count (confirm_count),
    .result        (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {1'b0, result.led, result.calib, 3'(result.mode)};
    end
  end

  // Unused padding bits of the input word
  logic unused_pad;
  assign unused_pad = ^in_data[IN_DATA_W-1:73];

endmodule

`default_nettype wire

@@ rtl/core/fms_core.sv @@
// ----------------------------------------------------------------------------
// Flight mode supervisor decision core
// Holds the supervisor state and applies one input word per step: request
// confirmation, transition rules, panic timing and calibration tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              step,
  input  wire fms_pkg::item_t              item,
  input  wire [fms_pkg::CFG_DATA_W-1:0]    panic_hold_us,
  input  wire [fms_pkg::CONFIRM_W-1:0]     confirm_count,
  output fms_pkg::result_t                 result
);
  import fms_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

  // State registers
  mode_t                mode;
  logic [2:0]           last_req;
  logic [2:0]           rep_cnt;
  logic                 checking;
  logic                 calib;
  logic [TIME_BITS-1:0] stamp;
  logic                 stamp_valid;

  mode_t                mode_next;
  logic [2:0]           last_req_next;
  logic [2:0]           rep_cnt_next;
  logic                 checking_next;
  logic                 calib_next;
  logic [TIME_BITS-1:0] stamp_next;
  logic                 stamp_valid_next;

  logic                 apply;
  logic [2:0]           target;
  logic [CMP_W-1:0]     now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 hold_done;
  logic                 req_ok;

  // Time stamp arithmetic, modulo 2^TIME_BITS
  assign now_wide  = CMP_W'(item.now);
  assign now_t     = now_wide[TIME_BITS-1:0];
  assign elapsed   = now_t - stamp;
  assign hold_done = CMP_W'(elapsed) > CMP_W'(panic_hold_us);
  assign req_ok    = item.req <= 3'(MODE_FULL);

  // Next state for the word in hand
  always_comb begin
    mode_next        = mode;
    last_req_next    = last_req;
    rep_cnt_next     = rep_cnt;
    checking_next    = checking;
    calib_next       = calib;
    stamp_next       = stamp;
    stamp_valid_next = stamp_valid;
    apply            = 1'b0;
    target           = 3'(MODE_SAFE);

    case (item.func)
      FN_MODE_MSG: begin
        // Track repeated requests
        if (req_ok && mode != MODE_PANIC) begin
          checking_next = item.req != 3'(mode);
          if (checking_next && item.req == last_req) begin
            rep_cnt_next = rep_cnt + 3'd1;
          end else begin
            rep_cnt_next = 3'd0;
          end
          last_req_next = item.req;
        end
        // Confirmed: try the change and restart tracking
        if (rep_cnt_next == confirm_count) begin
          apply         = 1'b1;
          target        = item.req;
          checking_next = 1'b0;
          rep_cnt_next  = 3'd0;
        end
      end
      FN_PANIC_CHECK: begin
        apply  = mode == MODE_PANIC;
        target = 3'(MODE_SAFE);
      end
      FN_FAULT: begin
        apply  = mode != MODE_SAFE;
        target = 3'(MODE_PANIC);
      end
      FN_CALIB_DONE: begin
        if (mode == MODE_CALIB) begin
          calib_next = 1'b1;
          mode_next  = MODE_SAFE;
        end
      end
      default: begin
        apply = 1'b0;
      end
    endcase

    // Transition rules
    if (apply && target != 3'(mode)) begin
      case (mode)
        MODE_SAFE: begin
          if (item.neutral) begin
            if (target == 3'(MODE_MANUAL) || target == 3'(MODE_CALIB)) begin
              mode_next = mode_t'(target);
            end else if ((target == 3'(MODE_YAW) || target == 3'(MODE_FULL)) && calib) begin
              mode_next = mode_t'(target);
            end
          end
        end
        MODE_PANIC: begin
          if (target == 3'(MODE_SAFE) && stamp_valid && hold_done) begin
            mode_next        = MODE_SAFE;
            stamp_next       = '0;
            stamp_valid_next = 1'b0;
          end
        end
        MODE_MANUAL, MODE_YAW, MODE_FULL: begin
          if (target == 3'(MODE_PANIC) || target == 3'(MODE_SAFE)) begin
            if (mode != MODE_MANUAL) begin
              calib_next = 1'b0;
            end
            mode_next        = MODE_PANIC;
            stamp_next       = now_t;
            stamp_valid_next = 1'b1;
          end
        end
        MODE_CALIB: begin
          if (target == 3'(MODE_SAFE) || target == 3'(MODE_PANIC)) begin
            mode_next = MODE_SAFE;
          end
        end
        default: begin
          mode_next = MODE_PANIC;
        end
      endcase
    end
  end

  // Advance state on each word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SAFE;
      last_req    <= 3'd0;
      rep_cnt     <= 3'd0;
      checking    <= 1'b0;
      calib       <= 1'b0;
      stamp       <= '0;
      stamp_valid <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      last_req    <= last_req_next;
      rep_cnt     <= rep_cnt_next;
      checking    <= checking_next;
      calib       <= calib_next;
      stamp       <= stamp_next;
      stamp_valid <= stamp_valid_next;
    end
  end

  // Result for this word
  assign result.mode  = mode_next;
  assign result.calib = calib_next;
  assign result.led   = 3'(mode_next) + 3'd1;

endmodule

`default_nettype wire

@@ rtl/core/fms_checker.sv @@
// ----------------------------------------------------------------------------
// Flight mode supervisor port checker
// Watches the top level ports for result consistency and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module fms_checker (
  input wire       clk,
  input wire       rst,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata
);
  import fms_pkg::*;

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // LED code tracks the mode
  a_led: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[6:4] == m_axis_tdata[2:0] + 3'd1)
    else $error("led code does not match mode");

  // Yaw and full modes need calibration
  a_calib: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:0] == 3'(MODE_YAW) ||
                      m_axis_tdata[2:0] == 3'(MODE_FULL)) |-> m_axis_tdata[3])
    else $error("yaw or full mode without calibration");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind flight_mode_supervisor fms_checker u_fms_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
